/* rtl/lsee_pkg.sv */
// Shared types, command codes and constants of the LED strip effect engine.
package lsee_pkg;

    // Fixed field widths.
    localparam int IDX_W    = 6;
    localparam int COLOR_W  = 32;
    localparam int BRIGHT_W = 8;
    localparam int PHASE_W  = 2;
    localparam int SEL_W    = 3;

    // Command codes carried in the op field.
    typedef enum logic [2:0] {
        OP_WRITE_PIXEL = 3'd0,
        OP_SET_ALL     = 3'd1,
        OP_GLOW_START  = 3'd2,
        OP_GLOW_STEP   = 3'd3,
        OP_RUN_START   = 3'd4,
        OP_RUN_STEP    = 3'd5,
        OP_BRIGHTER    = 3'd6,
        OP_DARKER      = 3'd7
    } t_op;

    // Glow, chaser and brightness constants.
    localparam logic [7:0] GLOW_UP_LIMIT   = 8'd240;
    localparam logic [7:0] GLOW_DELTA      = 8'd8;
    localparam logic [7:0] FADE_LIMIT      = 8'd230;
    localparam logic [7:0] FADE_DELTA      = 8'd25;
    localparam logic [7:0] FADE_START      = 8'd5;
    localparam logic [7:0] BRIGHT_MIN_STEP = 8'd16;
    localparam logic [7:0] BRIGHT_FULL     = 8'd255;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // a command beat is taken this cycle
        logic run_wr;   // write the chaser colour at the chaser position
        logic rd_en;    // read one pixel for the sweep
        logic rd_last;  // the read is of the final pixel
    } t_dp_cmd;

    // Colour table of the chaser.
    function automatic logic [31:0] run_color(input logic [2:0] sel);
        logic [31:0] col;
        case (sel)
            3'd0:    col = 32'h0000_00ff;
            3'd1:    col = 32'h0000_ff00;
            3'd2:    col = 32'h00ff_0000;
            3'd3:    col = 32'h0000_ffff;
            3'd4:    col = 32'h00ff_ff00;
            3'd5:    col = 32'h00ff_ff00;
            3'd6:    col = 32'h00ff_00ff;
            default: col = 32'hff00_0000;
        endcase
        return col;
    endfunction

endpackage

/* rtl/lsee_ctrl.sv */
// Controller of the LED strip effect engine: command sequencing and the pixel sweep.
module lsee_ctrl #(
    parameter int PIXEL_COUNT = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2:0]            i_op,
    output logic                  o_busy,
    output lsee_pkg::t_dp_cmd     o_cmd,
    output logic [((PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1)-1:0] o_rd_addr
);

    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_SWEEP,
        S_DRAIN
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_addr;
    logic                s_accept;
    logic                s_last;

    assign s_accept = i_start && (r_state == S_IDLE);
    assign s_last   = (r_addr == ADDR_W'(PIXEL_COUNT - 1));

    assign o_busy          = (r_state != S_IDLE);
    assign o_cmd.accept    = s_accept;
    assign o_cmd.run_wr    = (r_state == S_RUN);
    assign o_cmd.rd_en     = (r_state == S_SWEEP);
    assign o_cmd.rd_last   = (r_state == S_SWEEP) && s_last;
    assign o_rd_addr       = r_addr;

    // State register and sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    if (s_accept) begin
                        case (lsee_pkg::t_op'(i_op))
                            lsee_pkg::OP_WRITE_PIXEL,
                            lsee_pkg::OP_GLOW_START: r_state <= S_IDLE;
                            lsee_pkg::OP_RUN_STEP:   r_state <= S_RUN;
                            default:                 r_state <= S_SWEEP;
                        endcase
                    end
                end
                S_RUN: begin
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (s_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A run step writes the chaser pixel before the sweep starts.
    a_run_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (lsee_pkg::t_op'(i_op) == lsee_pkg::OP_RUN_STEP)) |=> o_cmd.run_wr)
        else $error("run step did not write the chaser pixel");

    // The final read is followed by a flush state without reads.
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_last |=> (r_state == S_DRAIN) && !o_cmd.rd_en)
        else $error("sweep did not drain after the final pixel");

    // Commands without results leave the block free in the next cycle.
    a_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && ((lsee_pkg::t_op'(i_op) == lsee_pkg::OP_WRITE_PIXEL) ||
                      (lsee_pkg::t_op'(i_op) == lsee_pkg::OP_GLOW_START))) |=> !o_busy)
        else $error("single-cycle command left the block busy");

endmodule

/* rtl/lsee_dp.sv */
// Datapath of the LED strip effect engine: pixel memories, effect state and result beats.
module lsee_dp #(
    parameter int PIXEL_COUNT = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lsee_pkg::t_dp_cmd     i_cmd,
    input  logic [((PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1)-1:0] i_rd_addr,
    input  logic [2:0]            i_op,
    input  logic [5:0]            i_pixel_index,
    input  logic [31:0]           i_color_word,
    input  logic [1:0]            i_fade_phase,
    output logic                  o_out_valid,
    output logic [5:0]            o_out_pixel,
    output logic [31:0]           o_out_color,
    output logic [7:0]            o_out_brightness,
    output logic                  o_last_pixel
);

    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    // Effect state.
    logic [7:0]              r_bright;
    logic [5:0]              r_pos;
    logic [2:0]              r_sel;
    logic [7:0]              r_fade;
    logic [PIXEL_COUNT-1:0]  r_pix_vld;
    logic [PIXEL_COUNT-1:0]  r_ph_vld;
    lsee_pkg::t_op           r_op;
    logic [31:0]             r_fill;

    // Pixel and phase memories.
    logic [31:0]             mem_pix [PIXEL_COUNT];
    logic [1:0]              mem_ph  [PIXEL_COUNT];

    // Read stage.
    logic                    r_rd_vld;
    logic                    r_rd_last;
    logic [ADDR_W-1:0]       r_rd_idx;
    logic [31:0]             r_rd_pix;
    logic [1:0]              r_rd_ph;
    logic                    r_rd_pv;
    logic                    r_rd_phv;

    // Output stage.
    logic                    r_out_vld;
    logic [5:0]              r_out_pixel;
    logic [31:0]             r_out_color;
    logic [7:0]              r_out_bright;
    logic                    r_out_last;

    lsee_pkg::t_op           s_op_in;
    logic [31:0]             s_cur_pix;
    logic [1:0]              s_cur_ph;
    logic [1:0]              g_p;
    logic [1:0]              g_q;
    logic [7:0]              g_down;
    logic [7:0]              g_up;
    logic [7:0]              g_down_new;
    logic [7:0]              g_up_new;
    logic                    g_advance;
    logic [31:0]             g_col;
    logic [1:0]              g_ph_new;
    logic [31:0]             s_emit_col;
    logic [31:0]             s_table_col;
    logic [15:0]             s_prod [4];
    logic [31:0]             s_run_col;
    logic [7:0]              s_bstep;
    logic [8:0]              s_bsum;
    logic [7:0]              n_bright_up;
    logic [7:0]              n_bright_dn;
    logic [5:0]              s_pos0;
    logic [6:0]              s_pos_inc;
    logic [7:0]              n_fade;
    logic [5:0]              n_pos;
    logic [2:0]              n_sel;
    logic                    s_wp_ok;
    logic                    s_wb;
    logic                    s_pix_we;
    logic [ADDR_W-1:0]       s_pix_wa;
    logic [31:0]             s_pix_wd;
    logic                    s_ph_we;
    logic [ADDR_W-1:0]       s_ph_wa;
    logic [1:0]              s_ph_wd;

    assign s_op_in = lsee_pkg::t_op'(i_op);

    // Entries never written since reset read as zero, pixel entries also those not written since a run start.
    assign s_cur_pix = r_rd_pv  ? r_rd_pix : '0;
    assign s_cur_ph  = r_rd_phv ? r_rd_ph  : '0;

    // Glow step of one pixel: rising byte up eight, falling byte down eight if above eight, or advance the phase.
    always_comb begin
        g_p        = s_cur_ph;
        g_q        = g_p + 2'd1;
        g_down     = s_cur_pix[{g_p, 3'b000} +: 8];
        g_up       = s_cur_pix[{g_q, 3'b000} +: 8];
        g_advance  = (g_up >= lsee_pkg::GLOW_UP_LIMIT);
        g_up_new   = g_up + lsee_pkg::GLOW_DELTA;
        g_down_new = (g_down > lsee_pkg::GLOW_DELTA) ? (g_down - lsee_pkg::GLOW_DELTA) : g_down;
        for (int b = 0; b < 4; b++) begin
            if (!g_advance && (2'(b) == g_q)) begin
                g_col[b*8 +: 8] = g_up_new;
            end else if (!g_advance && (2'(b) == g_p)) begin
                g_col[b*8 +: 8] = g_down_new;
            end else begin
                g_col[b*8 +: 8] = s_cur_pix[b*8 +: 8];
            end
        end
        g_ph_new = g_advance ? g_q : g_p;
    end

    // Colour sent for the pixel in the read stage.
    always_comb begin
        case (r_op)
            lsee_pkg::OP_SET_ALL:   s_emit_col = r_fill;
            lsee_pkg::OP_GLOW_STEP: s_emit_col = g_col;
            default:                s_emit_col = s_cur_pix;
        endcase
    end

    // Chaser colour: each table byte scaled by the fade level.
    always_comb begin
        s_table_col = lsee_pkg::run_color(r_sel);
        for (int k = 0; k < 4; k++) begin
            s_prod[k] = 16'(s_table_col[k*8 +: 8]) * 16'(r_fade);
            s_run_col[k*8 +: 8] = s_prod[k][15:8];
        end
    end

    // Brightness steps of an eighth, at least sixteen.
    always_comb begin
        s_bstep     = (r_bright[7:3] < 5'(lsee_pkg::BRIGHT_MIN_STEP)) ?
                      lsee_pkg::BRIGHT_MIN_STEP : {3'b000, r_bright[7:3]};
        s_bsum      = {1'b0, r_bright} + {1'b0, s_bstep};
        n_bright_up = (s_bsum >= {1'b0, lsee_pkg::BRIGHT_FULL}) ?
                      lsee_pkg::BRIGHT_FULL : s_bsum[7:0];
        n_bright_dn = (r_bright > s_bstep) ? (r_bright - s_bstep) : r_bright;
    end

    // Chaser advance: fade in, then move on to the next pixel, and to the next colour after the last pixel.
    always_comb begin
        s_pos0    = (7'(r_pos) >= 7'(PIXEL_COUNT)) ? '0 : r_pos;
        s_pos_inc = 7'(s_pos0) + 7'd1;
        n_sel     = r_sel;
        if (r_fade < lsee_pkg::FADE_LIMIT) begin
            n_fade = r_fade + lsee_pkg::FADE_DELTA;
            n_pos  = s_pos0;
        end else begin
            n_fade = lsee_pkg::FADE_START;
            if (s_pos_inc >= 7'(PIXEL_COUNT)) begin
                n_pos = '0;
                n_sel = r_sel + 3'd1;
            end else begin
                n_pos = s_pos_inc[5:0];
            end
        end
    end

    // Memory write selection; the three sources never coincide.
    always_comb begin
        s_wp_ok  = i_cmd.accept && (s_op_in == lsee_pkg::OP_WRITE_PIXEL) &&
                   (7'(i_pixel_index) < 7'(PIXEL_COUNT));
        s_wb     = r_rd_vld && ((r_op == lsee_pkg::OP_SET_ALL) ||
                                (r_op == lsee_pkg::OP_GLOW_STEP));
        s_pix_we = s_wp_ok || i_cmd.run_wr || s_wb;
        if (s_wp_ok) begin
            s_pix_wa = i_pixel_index[ADDR_W-1:0];
            s_pix_wd = i_color_word;
        end else if (i_cmd.run_wr) begin
            s_pix_wa = r_pos[ADDR_W-1:0];
            s_pix_wd = s_run_col;
        end else begin
            s_pix_wa = r_rd_idx;
            s_pix_wd = s_emit_col;
        end
        s_ph_we = s_wp_ok || (r_rd_vld && (r_op == lsee_pkg::OP_GLOW_STEP));
        s_ph_wa = s_wp_ok ? i_pixel_index[ADDR_W-1:0] : r_rd_idx;
        s_ph_wd = s_wp_ok ? i_fade_phase : g_ph_new;
    end

    // Effect state, valid bits and beat strobes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright  <= lsee_pkg::BRIGHT_FULL;
            r_pos     <= '0;
            r_sel     <= '0;
            r_fade    <= '0;
            r_pix_vld <= '0;
            r_ph_vld  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.rd_en;
            r_out_vld <= r_rd_vld;
            if (i_cmd.accept) begin
                case (s_op_in)
                    lsee_pkg::OP_GLOW_START: begin
                        r_bright <= lsee_pkg::BRIGHT_FULL;
                    end
                    lsee_pkg::OP_RUN_START: begin
                        r_bright <= lsee_pkg::BRIGHT_FULL;
                        r_pos    <= '0;
                        r_sel    <= '0;
                        r_fade   <= lsee_pkg::FADE_START;
                    end
                    lsee_pkg::OP_RUN_STEP: begin
                        r_pos  <= n_pos;
                        r_sel  <= n_sel;
                        r_fade <= n_fade;
                    end
                    lsee_pkg::OP_BRIGHTER: begin
                        r_bright <= n_bright_up;
                    end
                    lsee_pkg::OP_DARKER: begin
                        r_bright <= n_bright_dn;
                    end
                    default: begin
                    end
                endcase
            end
            // A run start clears the whole strip at once.
            if (i_cmd.accept && (s_op_in == lsee_pkg::OP_RUN_START)) begin
                r_pix_vld <= '0;
            end else if (s_pix_we) begin
                r_pix_vld[s_pix_wa] <= 1'b1;
            end
            if (s_ph_we) begin
                r_ph_vld[s_ph_wa] <= 1'b1;
            end
        end
    end

    // Memories, read stage and output registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= s_op_in;
            r_fill <= i_color_word;
        end
        if (s_pix_we) begin
            mem_pix[s_pix_wa] <= s_pix_wd;
        end
        if (s_ph_we) begin
            mem_ph[s_ph_wa] <= s_ph_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_pix <= mem_pix[i_rd_addr];
            r_rd_ph  <= mem_ph[i_rd_addr];
            r_rd_pv  <= r_pix_vld[i_rd_addr];
            r_rd_phv <= r_ph_vld[i_rd_addr];
        end
        r_rd_idx     <= i_rd_addr;
        r_rd_last    <= i_cmd.rd_last;
        r_out_pixel  <= 6'(r_rd_idx);
        r_out_color  <= s_emit_col;
        r_out_bright <= r_bright;
        r_out_last   <= r_rd_last;
    end

    assign o_out_valid      = r_out_vld;
    assign o_out_pixel      = r_out_pixel;
    assign o_out_color      = r_out_color;
    assign o_out_brightness = r_out_bright;
    assign o_last_pixel     = r_out_vld && r_out_last;

    // Pixels of one transfer leave in ascending order without gaps.
    a_pixel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |=>
            (r_out_vld && (r_out_pixel == 6'($past(r_out_pixel) + 6'd1))))
        else $error("pixel beats out of order");

    // Brightness does not change while a transfer is under way.
    a_bright_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_bright == r_bright))
        else $error("brightness changed during a transfer");

endmodule

/* rtl/led_strip_effect_engine_core.sv */
// Top level of the LED strip effect engine: controller and datapath.
//
// One command is taken when start is high and busy is low. Write_pixel and
// glow_start send no beats and busy stays low. Every other command streams
// all PIXEL_COUNT pixels from pixel 0, one beat per cycle on o_out_valid,
// with o_last_pixel on the final one; the receiver cannot stall, so each
// beat must be taken in the cycle it is shown. The stream is paced by the
// single read port of the pixel memory, one pixel per cycle: set_all,
// glow_step, run_start, brighter and darker keep busy high through the sweep
// and a drain state, run_step also through a state that writes the chaser
// pixel first. Each beat passes a read stage and an output register, and
// the last beat shows in the first cycle in which busy is low again.
module led_strip_effect_engine_core #(
    parameter int PIXEL_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [5:0]  i_pixel_index,
    input  logic [31:0] i_color_word,
    input  logic [1:0]  i_fade_phase,
    output logic        o_out_valid,
    output logic [5:0]  o_out_pixel,
    output logic [31:0] o_out_color,
    output logic [7:0]  o_out_brightness,
    output logic        o_last_pixel
);

    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    lsee_pkg::t_dp_cmd   s_cmd;
    logic [ADDR_W-1:0]   s_rd_addr;

    lsee_ctrl #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_op      (i_op),
        .o_busy    (busy),
        .o_cmd     (s_cmd),
        .o_rd_addr (s_rd_addr)
    );

    lsee_dp #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .i_rd_addr        (s_rd_addr),
        .i_op             (i_op),
        .i_pixel_index    (i_pixel_index),
        .i_color_word     (i_color_word),
        .i_fade_phase     (i_fade_phase),
        .o_out_valid      (o_out_valid),
        .o_out_pixel      (o_out_pixel),
        .o_out_color      (o_out_color),
        .o_out_brightness (o_out_brightness),
        .o_last_pixel     (o_last_pixel)
    );

endmodule

/* tb/sv/lsee_sweep_checker.sv */
// Watches the command and pixel channels of the effect engine, predicts every pixel beat and compares.
module lsee_sweep_checker
    import lsee_pkg::*;
#(
    parameter int PIXEL_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_op,
    input  logic [5:0]  i_pixel_index,
    input  logic [31:0] i_color_word,
    input  logic [1:0]  i_fade_phase,
    input  logic        i_out_valid,
    input  logic [5:0]  i_out_pixel,
    input  logic [31:0] i_out_color,
    input  logic [7:0]  i_out_brightness,
    input  logic        i_last_pixel,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    // One expected pixel beat of a sweep.
    typedef struct packed {
        logic [5:0]  pixel;
        logic [31:0] color;
        logic [7:0]  bright;
        logic        is_last;
    } t_pixel_beat;

    // Chaser colours, entry 0 in the lowest word.
    localparam logic [7:0][31:0] CHASE_COLORS = {
        32'hff00_0000, 32'h00ff_00ff, 32'h00ff_ff00, 32'h00ff_ff00,
        32'h0000_ffff, 32'h00ff_0000, 32'h0000_ff00, 32'h0000_00ff
    };

    // Predicted state of the strip.
    logic [31:0] color_mem [PIXEL_COUNT];
    logic [1:0]  phase_mem [PIXEL_COUNT];
    logic [7:0]  bright_level;
    logic [5:0]  chase_pos;
    logic [2:0]  chase_sel;
    logic [7:0]  fade_lvl;

    t_pixel_beat expected_beats [$];
    int unsigned fail_total = 0;

    task automatic reset_model();
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            color_mem[i] = '0;
            phase_mem[i] = '0;
        end
        bright_level = BRIGHT_FULL;
        chase_pos    = '0;
        chase_sel    = '0;
        fade_lvl     = '0;
        expected_beats.delete();
    endtask

    // The brightness step is an eighth of the level, but never below the minimum.
    function automatic logic [7:0] bright_step_of(input logic [7:0] level);
        return ((level >> 3) < BRIGHT_MIN_STEP) ? BRIGHT_MIN_STEP : (level >> 3);
    endfunction

    // Raises the next byte by a glow delta and lowers the phase byte by one if above it, or advances the phase.
    task automatic glow_all_pixels();
        logic [1:0]  p;
        logic [1:0]  q;
        logic [7:0]  down;
        logic [7:0]  up;
        logic [31:0] col;
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            col  = color_mem[i];
            p    = phase_mem[i];
            q    = p + 2'd1;
            down = col[p*8 +: 8];
            up   = col[q*8 +: 8];
            if (up < GLOW_UP_LIMIT) begin
                up = up + GLOW_DELTA;
                if (down > GLOW_DELTA) begin
                    down = down - GLOW_DELTA;
                end
                col[p*8 +: 8] = down;
                col[q*8 +: 8] = up;
            end else begin
                phase_mem[i] = q;
            end
            color_mem[i] = col;
        end
    endtask

    // Fades the chaser up, or moves it on, and writes its scaled colour.
    task automatic advance_chaser();
        logic [31:0] base;
        logic [31:0] col;
        logic [15:0] prod;
        if (int'(chase_pos) >= PIXEL_COUNT) begin
            chase_pos = '0;
        end
        if (fade_lvl < FADE_LIMIT) begin
            fade_lvl = fade_lvl + FADE_DELTA;
        end else begin
            fade_lvl = FADE_START;
            if (int'(chase_pos) + 1 >= PIXEL_COUNT) begin
                chase_pos = '0;
                chase_sel = chase_sel + 3'd1;
            end else begin
                chase_pos = chase_pos + 6'd1;
            end
        end
        base = CHASE_COLORS[chase_sel];
        col  = '0;
        for (int k = 0; k < 4; k++) begin
            prod = base[k*8 +: 8] * fade_lvl;
            col[k*8 +: 8] = prod[15:8];
        end
        color_mem[chase_pos] = col;
    endtask

    // A sweep sends every pixel from pixel 0 with the current brightness.
    task automatic queue_sweep();
        t_pixel_beat beat;
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            beat.pixel   = 6'(i);
            beat.color   = color_mem[i];
            beat.bright  = bright_level;
            beat.is_last = (i == PIXEL_COUNT - 1);
            expected_beats.push_back(beat);
        end
    endtask

    task automatic apply_command(input t_op op, input logic [5:0] idx,
                                 input logic [31:0] color, input logic [1:0] phase);
        logic [7:0] step;
        logic [8:0] sum;
        step = bright_step_of(bright_level);
        case (op)
            OP_WRITE_PIXEL: begin
                // Writes beyond the strip are dropped.
                if (int'(idx) < PIXEL_COUNT) begin
                    color_mem[idx] = color;
                    phase_mem[idx] = phase;
                end
            end
            OP_SET_ALL: begin
                for (int i = 0; i < PIXEL_COUNT; i++) begin
                    color_mem[i] = color;
                end
            end
            OP_GLOW_START: begin
                bright_level = BRIGHT_FULL;
            end
            OP_GLOW_STEP: begin
                glow_all_pixels();
            end
            OP_RUN_START: begin
                bright_level = BRIGHT_FULL;
                for (int i = 0; i < PIXEL_COUNT; i++) begin
                    color_mem[i] = '0;
                end
                chase_pos = '0;
                chase_sel = '0;
                fade_lvl  = FADE_START;
            end
            OP_RUN_STEP: begin
                advance_chaser();
            end
            OP_BRIGHTER: begin
                sum = {1'b0, bright_level} + step;
                bright_level = (sum >= {1'b0, BRIGHT_FULL}) ? BRIGHT_FULL : sum[7:0];
            end
            default: begin
                if (bright_level > step) begin
                    bright_level = bright_level - step;
                end
            end
        endcase
        if (op != OP_WRITE_PIXEL && op != OP_GLOW_START) begin
            queue_sweep();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_total++;
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Compares one pixel beat with the oldest prediction.
    task automatic check_beat();
        t_pixel_beat want;
        if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat, pixel", 32'hffff_ffff, 32'(i_out_pixel));
        end else begin
            want = expected_beats.pop_front();
            if (i_out_pixel !== want.pixel) begin
                report_mismatch("pixel index", 32'(want.pixel), 32'(i_out_pixel));
            end
            if (i_out_color !== want.color) begin
                report_mismatch("colour", want.color, i_out_color);
            end
            if (i_out_brightness !== want.bright) begin
                report_mismatch("brightness", 32'(want.bright), 32'(i_out_brightness));
            end
            if (i_last_pixel !== want.is_last) begin
                report_mismatch("last pixel", 32'(want.is_last), 32'(i_last_pixel));
            end
        end
    endtask

    // Beats are checked before a command taken at the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid === 1'b1) begin
                check_beat();
            end else if (i_out_valid !== 1'b0) begin
                report_mismatch("beat strobe", 32'd0, 32'(i_out_valid));
            end
            if (i_start && !i_busy) begin
                apply_command(t_op'(i_op), i_pixel_index, i_color_word, i_fade_phase);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_beats.size();
    end

endmodule

/* tb/sv/tb.sv */
// Top of the effect engine testbench: clock, reset, command stimulus and the verdict.
module tb;
    import lsee_pkg::*;

    localparam int          PIXEL_COUNT  = 32;
    localparam int unsigned RANDOM_ITEMS = 250;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_op;
    logic [5:0]  i_pixel_index;
    logic [31:0] i_color_word;
    logic [1:0]  i_fade_phase;
    logic        o_out_valid;
    logic [5:0]  o_out_pixel;
    logic [31:0] o_out_color;
    logic [7:0]  o_out_brightness;
    logic        o_last_pixel;

    int unsigned fail_count;
    int unsigned pending_beats;
    int unsigned cycle_count = 0;
    int unsigned sent_count = 0;
    bit          gaps_on = 1'b1;

    led_strip_effect_engine_core #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_pixel_index   (i_pixel_index),
        .i_color_word    (i_color_word),
        .i_fade_phase    (i_fade_phase),
        .o_out_valid     (o_out_valid),
        .o_out_pixel     (o_out_pixel),
        .o_out_color     (o_out_color),
        .o_out_brightness(o_out_brightness),
        .o_last_pixel    (o_last_pixel)
    );

    lsee_sweep_checker #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) u_sweep_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_op            (i_op),
        .i_pixel_index   (i_pixel_index),
        .i_color_word    (i_color_word),
        .i_fade_phase    (i_fade_phase),
        .i_out_valid     (o_out_valid),
        .i_out_pixel     (o_out_pixel),
        .i_out_color     (o_out_color),
        .i_out_brightness(o_out_brightness),
        .i_last_pixel    (o_last_pixel),
        .o_fail_count    (fail_count),
        .o_pending       (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Holds the next command back for a while; most gaps are short, a few long.
    task automatic pause_sender();
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55) begin
            gap = 0;
        end else if (roll < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(4, 45);
        end
        if (gap > 0) begin
            start         = 1'b0;
            i_op          = 3'($urandom);
            i_pixel_index = 6'($urandom);
            i_color_word  = $urandom;
            i_fade_phase  = 2'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Presents one command beat from a falling edge and waits until it is taken.
    task automatic send_command(input t_op op, input logic [5:0] idx,
                                input logic [31:0] color, input logic [1:0] phase);
        start         = 1'b1;
        i_op          = op;
        i_pixel_index = idx;
        i_color_word  = color;
        i_fade_phase  = phase;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        @(negedge i_clk);
        if (op != OP_WRITE_PIXEL || int'(idx) < PIXEL_COUNT) begin
            sent_count++;
        end
        pause_sender();
    endtask

    // Commands that ignore the payload get random filler in it.
    task automatic send_op(input t_op op);
        send_command(op, 6'($urandom), $urandom, 2'($urandom));
    endtask

    // Colour bytes lean towards both ends of the glow clamps.
    function automatic logic [31:0] glow_color();
        logic [31:0] col;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3))
                0:       col[k*8 +: 8] = 8'($urandom_range(0, 16));
                1:       col[k*8 +: 8] = 8'($urandom_range(228, 255));
                default: col[k*8 +: 8] = 8'($urandom);
            endcase
        end
        return col;
    endfunction

    initial begin
        int unsigned target;
        int unsigned n;
        logic [5:0]  idx;

        start         = 1'b0;
        i_rst_n       = 1'b0;
        i_op          = OP_WRITE_PIXEL;
        i_pixel_index = '0;
        i_color_word  = '0;
        i_fade_phase  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: a chaser step before any run start, brightness at full.
        send_op(OP_RUN_STEP);
        send_op(OP_BRIGHTER);
        // Extreme indexes and colours; writes past the strip must be dropped.
        send_command(OP_WRITE_PIXEL, 6'd0, 32'h0000_0000, 2'd0);
        send_command(OP_WRITE_PIXEL, 6'd31, 32'hffff_ffff, 2'd3);
        send_command(OP_WRITE_PIXEL, 6'd32, 32'h1234_5678, 2'd1);
        send_command(OP_WRITE_PIXEL, 6'd63, 32'hdead_beef, 2'd2);
        // Up byte already at the limit, a down byte that reaches the floor, phase wrap.
        send_command(OP_WRITE_PIXEL, 6'd1, 32'h00f0_0810, 2'd1);
        send_command(OP_WRITE_PIXEL, 6'd2, 32'h0000_0910, 2'd0);
        send_command(OP_WRITE_PIXEL, 6'd3, 32'hef00_00ff, 2'd3);
        // Glow start must leave the phases alone and send nothing.
        send_op(OP_GLOW_START);
        send_op(OP_GLOW_STEP);
        send_op(OP_GLOW_STEP);
        send_command(OP_SET_ALL, 6'd0, 32'hffff_ffff, 2'd0);
        send_op(OP_GLOW_STEP);
        send_command(OP_SET_ALL, 6'd63, 32'h0000_0000, 2'd3);
        send_op(OP_DARKER);
        send_op(OP_DARKER);
        send_op(OP_BRIGHTER);
        send_op(OP_GLOW_START);
        send_op(OP_RUN_START);
        repeat (5) send_op(OP_RUN_STEP);

        // Random part: mostly well-formed effect sequences, some noise.
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        if ($urandom_range(0, 9) == 0) begin
                            idx = 6'($urandom);
                        end else begin
                            idx = 6'($urandom_range(0, PIXEL_COUNT - 1));
                        end
                        send_command(OP_WRITE_PIXEL, idx, glow_color(), 2'($urandom));
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        send_op(OP_GLOW_START);
                    end
                    n = $urandom_range(1, 6);
                    repeat (n) send_op(OP_GLOW_STEP);
                end
                3, 4, 5: begin
                    if ($urandom_range(0, 3) != 0) begin
                        send_op(OP_RUN_START);
                    end
                    n = $urandom_range(3, 25);
                    repeat (n) send_op(OP_RUN_STEP);
                end
                6: begin
                    n = $urandom_range(1, 10);
                    repeat (n) send_op($urandom_range(0, 1) ? OP_BRIGHTER : OP_DARKER);
                end
                7: begin
                    send_command(OP_SET_ALL, 6'($urandom), glow_color(), 2'($urandom));
                    if ($urandom_range(0, 1) == 0) begin
                        send_op(OP_GLOW_STEP);
                    end
                end
                8: begin
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        send_command(t_op'($urandom_range(0, 7)), 6'($urandom), $urandom,
                                     2'($urandom));
                    end
                end
                default: begin
                    send_op(OP_GLOW_START);
                    send_command(t_op'($urandom_range(0, 7)), 6'($urandom), $urandom,
                                 2'($urandom));
                end
            endcase
        end
        start = 1'b0;

        // Drain the last sweep, then give stray beats a chance to show.
        while (pending_beats != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending_beats == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
